// ===== sv/tbg_pkg.sv =====
// Shared constants for the triangle tangent and bitangent block.
`timescale 1ns / 1ps
`default_nettype none
package tbg_pkg;
    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_BITS = 3;
    localparam logic [CFG_BITS-1:0] GROUP_SIZE_RESET = 3'd3;

    localparam int JOB_FIELDS = 10;
    localparam int J_DU1 = 0;
    localparam int J_DV1 = 1;
    localparam int J_DU2 = 2;
    localparam int J_DV2 = 3;
    localparam int J_EA0 = 4;
    localparam int J_EA1 = 5;
    localparam int J_EA2 = 6;
    localparam int J_EB0 = 7;
    localparam int J_EB1 = 8;
    localparam int J_EB2 = 9;

    localparam logic [2:0] C_DET = 3'd0;
    localparam logic [2:0] C_TX = 3'd1;
    localparam logic [2:0] C_TY = 3'd2;
    localparam logic [2:0] C_TZ = 3'd3;
    localparam logic [2:0] C_BX = 3'd4;
    localparam logic [2:0] C_BY = 3'd5;
    localparam logic [2:0] C_BZ = 3'd6;
endpackage
`default_nettype wire

// ===== sv/triangle_tangent_bitangent.sv =====
// Top level of the triangle tangent and bitangent generator.
//
// Vertices enter on the in channel (in_valid, in_ready), one transaction per
// vertex, with position and texture coordinate in signed fixed point. The
// third vertex of each group yields one transaction on the out channel
// (out_valid, out_ready) carrying the shared tangent, bitangent and the
// degenerate flag. In a quad group the fourth vertex yields nothing.
// The cfg channel (cfg_valid, cfg_ready, cfg_data) sets the group size and
// is always ready; write it only while the block is idle.
// The front end takes the first two vertices of a group in one cycle each.
// The third vertex is taken as soon as the two-entry job queue has room.
// The back end computes the determinant and then each of the six components
// in turn, with the single shared multiplier and a divider that yields one
// quotient bit per cycle; an overflowing quotient skips the divider, and a
// zero determinant skips the six components.
// A stalled receiver holds the result and stops the back end; the front end
// keeps accepting vertices until the queue is full.
// Reset clears the vertex count, the queue and the back end, and sets the
// group size to a triangle.
`timescale 1ns / 1ps
`default_nettype none
module triangle_tangent_bitangent #(
    parameter int WORD_BITS = tbg_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = tbg_pkg::DEF_FRAC_BITS
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [tbg_pkg::CFG_BITS-1:0] cfg_data,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [WORD_BITS-1:0]         pos_x,
    input  wire  [WORD_BITS-1:0]         pos_y,
    input  wire  [WORD_BITS-1:0]         pos_z,
    input  wire  [WORD_BITS-1:0]         tex_u,
    input  wire  [WORD_BITS-1:0]         tex_v,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [WORD_BITS-1:0]         tangent_x,
    output logic [WORD_BITS-1:0]         tangent_y,
    output logic [WORD_BITS-1:0]         tangent_z,
    output logic [WORD_BITS-1:0]         bitangent_x,
    output logic [WORD_BITS-1:0]         bitangent_y,
    output logic [WORD_BITS-1:0]         bitangent_z,
    output logic                         degenerate
);
    localparam int JW = tbg_pkg::JOB_FIELDS * (WORD_BITS + 1);

    logic [tbg_pkg::CFG_BITS-1:0] group_size_reg;
    logic q_push_valid;
    logic q_push_ready;
    logic [JW-1:0] q_push_data;
    logic q_pop_valid;
    logic q_pop_ready;
    logic [JW-1:0] q_pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= tbg_pkg::GROUP_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            group_size_reg <= cfg_data;
        end
    end

    tbg_front #(
        .WORD_BITS(WORD_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .tex_u(tex_u),
        .tex_v(tex_v),
        .quad(group_size_reg[2]),
        .push_valid(q_push_valid),
        .push_ready(q_push_ready),
        .push_data(q_push_data)
    );

    tbg_queue #(
        .WIDTH(JW),
        .DEPTH(tbg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(q_push_valid),
        .push_ready(q_push_ready),
        .push_data(q_push_data),
        .pop_valid(q_pop_valid),
        .pop_ready(q_pop_ready),
        .pop_data(q_pop_data)
    );

    tbg_back #(
        .WORD_BITS(WORD_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .pop_valid(q_pop_valid),
        .pop_ready(q_pop_ready),
        .pop_data(q_pop_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .tangent_x(tangent_x),
        .tangent_y(tangent_y),
        .tangent_z(tangent_z),
        .bitangent_x(bitangent_x),
        .bitangent_y(bitangent_y),
        .bitangent_z(bitangent_z),
        .degenerate(degenerate)
    );

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> tangent_x == '0 && tangent_y == '0
            && tangent_z == '0 && bitangent_x == '0 && bitangent_y == '0
            && bitangent_z == '0)
        else $error("Degenerate result carries nonzero vectors.");

    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> q_push_valid && !q_push_ready)
        else $error("Input stalled while the job queue had room.");

    a_no_pop_while_holding: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop_valid && q_pop_ready |-> !out_valid)
        else $error("Job taken while a result is still pending.");
endmodule
`default_nettype wire

// ===== sv/tbg_front.sv =====
// Front end: holds the first two vertices of a group and forms edge and texture deltas.
`timescale 1ns / 1ps
`default_nettype none
module tbg_front #(
    parameter int WORD_BITS = tbg_pkg::DEF_WORD_BITS
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire  [WORD_BITS-1:0]                  pos_x,
    input  wire  [WORD_BITS-1:0]                  pos_y,
    input  wire  [WORD_BITS-1:0]                  pos_z,
    input  wire  [WORD_BITS-1:0]                  tex_u,
    input  wire  [WORD_BITS-1:0]                  tex_v,
    input  wire                                   quad,
    output logic                                  push_valid,
    input  wire                                   push_ready,
    output logic [tbg_pkg::JOB_FIELDS*(WORD_BITS+1)-1:0] push_data
);
    localparam int DW = WORD_BITS + 1;
    localparam logic [1:0] SLOT_V0 = 2'd0;
    localparam logic [1:0] SLOT_V1 = 2'd1;
    localparam logic [1:0] SLOT_V2 = 2'd2;
    localparam logic [1:0] SLOT_V3 = 2'd3;

    logic [1:0] corner_reg;
    logic [WORD_BITS-1:0] p0_reg [3];
    logic [WORD_BITS-1:0] p1_reg [3];
    logic [WORD_BITS-1:0] t0_reg [2];
    logic [WORD_BITS-1:0] t1_reg [2];
    logic accept;

    function automatic logic [DW-1:0] sdiff(input logic [WORD_BITS-1:0] a,
                                            input logic [WORD_BITS-1:0] b);
        return {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    endfunction

    assign push_valid = in_valid && (corner_reg == SLOT_V2);
    assign in_ready = (corner_reg != SLOT_V2) || push_ready;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        push_data = '0;
        push_data[tbg_pkg::J_DU1*DW +: DW] = sdiff(t1_reg[0], t0_reg[0]);
        push_data[tbg_pkg::J_DV1*DW +: DW] = sdiff(t1_reg[1], t0_reg[1]);
        push_data[tbg_pkg::J_DU2*DW +: DW] = sdiff(tex_u, t0_reg[0]);
        push_data[tbg_pkg::J_DV2*DW +: DW] = sdiff(tex_v, t0_reg[1]);
        push_data[tbg_pkg::J_EA0*DW +: DW] = sdiff(p1_reg[0], p0_reg[0]);
        push_data[tbg_pkg::J_EA1*DW +: DW] = sdiff(p1_reg[1], p0_reg[1]);
        push_data[tbg_pkg::J_EA2*DW +: DW] = sdiff(p1_reg[2], p0_reg[2]);
        push_data[tbg_pkg::J_EB0*DW +: DW] = sdiff(pos_x, p0_reg[0]);
        push_data[tbg_pkg::J_EB1*DW +: DW] = sdiff(pos_y, p0_reg[1]);
        push_data[tbg_pkg::J_EB2*DW +: DW] = sdiff(pos_z, p0_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg <= SLOT_V0;
        end
        else if (accept)
        begin
            unique case (corner_reg)
                SLOT_V0: corner_reg <= SLOT_V1;
                SLOT_V1: corner_reg <= SLOT_V2;
                SLOT_V2: corner_reg <= quad ? SLOT_V3 : SLOT_V0;
                SLOT_V3: corner_reg <= SLOT_V0;
                default: corner_reg <= SLOT_V0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && corner_reg == SLOT_V0)
        begin
            p0_reg[0] <= pos_x;
            p0_reg[1] <= pos_y;
            p0_reg[2] <= pos_z;
            t0_reg[0] <= tex_u;
            t0_reg[1] <= tex_v;
        end
        if (accept && corner_reg == SLOT_V1)
        begin
            p1_reg[0] <= pos_x;
            p1_reg[1] <= pos_y;
            p1_reg[2] <= pos_z;
            t1_reg[0] <= tex_u;
            t1_reg[1] <= tex_v;
        end
    end
endmodule
`default_nettype wire

// ===== sv/tbg_queue.sv =====
// Small register queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none
module tbg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tbg_pkg::QUEUE_DEPTH
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push_valid,
    output logic             push_ready,
    input  wire  [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  wire              pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [CW-1:0] count_reg;
    logic push_fire;
    logic pop_fire;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data = mem_reg[rd_reg];
    assign push_fire = push_valid && push_ready;
    assign pop_fire = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_reg <= bump(wr_reg);
            end
            if (pop_fire)
            begin
                rd_reg <= bump(rd_reg);
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

// ===== sv/tbg_back.sv =====
// Back end: shared multiplier, determinant, and bit-serial rounded divider per component.
`timescale 1ns / 1ps
`default_nettype none
module tbg_back #(
    parameter int WORD_BITS = tbg_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = tbg_pkg::DEF_FRAC_BITS
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   pop_valid,
    output logic                                  pop_ready,
    input  wire  [tbg_pkg::JOB_FIELDS*(WORD_BITS+1)-1:0] pop_data,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic [WORD_BITS-1:0]                  tangent_x,
    output logic [WORD_BITS-1:0]                  tangent_y,
    output logic [WORD_BITS-1:0]                  tangent_z,
    output logic [WORD_BITS-1:0]                  bitangent_x,
    output logic [WORD_BITS-1:0]                  bitangent_y,
    output logic [WORD_BITS-1:0]                  bitangent_z,
    output logic                                  degenerate
);
    localparam int W = WORD_BITS;
    localparam int DW = W + 1;
    localparam int JW = tbg_pkg::JOB_FIELDS * DW;
    localparam int PRW = 2 * DW;
    localparam int SW = 2 * W + 3;
    localparam int MW = 2 * W + 2;
    localparam int NW = MW + FRAC_BITS + 2;
    localparam int CNTW = $clog2(W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MA = 3'd1;
    localparam logic [2:0] S_MB = 3'd2;
    localparam logic [2:0] S_SUB = 3'd3;
    localparam logic [2:0] S_DIV = 3'd4;
    localparam logic [2:0] S_FIN = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] comp_reg;
    logic [JW-1:0] job_reg;
    logic signed [PRW-1:0] prod_reg;
    logic signed [PRW-1:0] acc_reg;
    logic det_neg_reg;
    logic [MW-1:0] dmag_reg;
    logic neg_reg;
    logic [MW:0] rem_reg;
    logic [W-1:0] nlow_reg;
    logic [W-1:0] q_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [W-1:0] res_reg [6];
    logic deg_reg;

    logic signed [DW-1:0] du1, dv1, du2, dv2, ea_sel, eb_sel, op_a, op_b;
    logic is_tan;
    logic signed [SW-1:0] diff;
    logic signed [SW-1:0] diff_abs;
    logic diff_neg;
    logic [MW-1:0] mag;
    logic [MW:0] dbl;
    logic [NW-1:0] num;
    logic [NW-1:0] num_hi;
    logic ovf;
    logic [MW+1:0] trial;
    logic trial_ge;
    logic [MW+1:0] trial_sub;
    logic [W-1:0] lim;
    logic [W-1:0] sat;
    logic [W-1:0] fin_val;

    assign du1 = job_reg[tbg_pkg::J_DU1*DW +: DW];
    assign dv1 = job_reg[tbg_pkg::J_DV1*DW +: DW];
    assign du2 = job_reg[tbg_pkg::J_DU2*DW +: DW];
    assign dv2 = job_reg[tbg_pkg::J_DV2*DW +: DW];

    always_comb
    begin
        unique case (comp_reg)
            tbg_pkg::C_TX, tbg_pkg::C_BX:
            begin
                ea_sel = job_reg[tbg_pkg::J_EA0*DW +: DW];
                eb_sel = job_reg[tbg_pkg::J_EB0*DW +: DW];
            end
            tbg_pkg::C_TY, tbg_pkg::C_BY:
            begin
                ea_sel = job_reg[tbg_pkg::J_EA1*DW +: DW];
                eb_sel = job_reg[tbg_pkg::J_EB1*DW +: DW];
            end
            default:
            begin
                ea_sel = job_reg[tbg_pkg::J_EA2*DW +: DW];
                eb_sel = job_reg[tbg_pkg::J_EB2*DW +: DW];
            end
        endcase
        is_tan = (comp_reg == tbg_pkg::C_TX) || (comp_reg == tbg_pkg::C_TY)
            || (comp_reg == tbg_pkg::C_TZ);
        if (comp_reg == tbg_pkg::C_DET)
        begin
            op_a = (state_reg == S_MA) ? du1 : du2;
            op_b = (state_reg == S_MA) ? dv2 : dv1;
        end
        else if (is_tan)
        begin
            op_a = (state_reg == S_MA) ? dv2 : dv1;
            op_b = (state_reg == S_MA) ? ea_sel : eb_sel;
        end
        else
        begin
            op_a = (state_reg == S_MA) ? du1 : du2;
            op_b = (state_reg == S_MA) ? eb_sel : ea_sel;
        end
    end

    always_comb
    begin
        diff = SW'(acc_reg) - SW'(prod_reg);
        diff_neg = diff[SW-1];
        diff_abs = diff_neg ? -diff : diff;
        mag = diff_abs[MW-1:0];
        dbl = {dmag_reg, 1'b0};
        num = (NW'(mag) << (FRAC_BITS + 1)) + NW'(dmag_reg);
        num_hi = num >> W;
        ovf = (num_hi >= NW'(dbl));
        trial = {rem_reg, nlow_reg[W-1]};
        trial_ge = (trial >= (MW+2)'(dbl));
        trial_sub = trial - (MW+2)'(dbl);
        lim = {1'b0, {(W-1){1'b1}}} + W'(neg_reg);
        sat = (q_reg > lim) ? lim : q_reg;
        fin_val = neg_reg ? (~sat + 1'b1) : sat;
    end

    assign pop_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign tangent_x = res_reg[0];
    assign tangent_y = res_reg[1];
    assign tangent_z = res_reg[2];
    assign bitangent_x = res_reg[3];
    assign bitangent_y = res_reg[4];
    assign bitangent_z = res_reg[5];
    assign degenerate = deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            comp_reg <= tbg_pkg::C_DET;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        comp_reg <= tbg_pkg::C_DET;
                        state_reg <= S_MA;
                    end
                end
                S_MA: state_reg <= S_MB;
                S_MB: state_reg <= S_SUB;
                S_SUB:
                begin
                    if (comp_reg == tbg_pkg::C_DET)
                    begin
                        if (diff == '0)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            comp_reg <= tbg_pkg::C_TX;
                            state_reg <= S_MA;
                        end
                    end
                    else
                    begin
                        state_reg <= ovf ? S_FIN : S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (comp_reg == tbg_pkg::C_BZ)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        comp_reg <= comp_reg + 1'b1;
                        state_reg <= S_MA;
                    end
                end
                S_DONE:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && pop_valid)
        begin
            job_reg <= pop_data;
        end
        if (state_reg == S_MA || state_reg == S_MB)
        begin
            prod_reg <= op_a * op_b;
        end
        if (state_reg == S_MB)
        begin
            acc_reg <= prod_reg;
        end
        if (state_reg == S_SUB)
        begin
            if (comp_reg == tbg_pkg::C_DET)
            begin
                det_neg_reg <= diff_neg;
                dmag_reg <= mag;
                deg_reg <= (diff == '0);
                if (diff == '0)
                begin
                    for (int i = 0; i < 6; i++)
                    begin
                        res_reg[i] <= '0;
                    end
                end
            end
            else
            begin
                neg_reg <= diff_neg ^ det_neg_reg;
                if (ovf)
                begin
                    q_reg <= '1;
                end
                else
                begin
                    rem_reg <= num_hi[MW:0];
                    nlow_reg <= num[W-1:0];
                    cnt_reg <= CNTW'(W - 1);
                end
            end
        end
        if (state_reg == S_DIV)
        begin
            rem_reg <= trial_ge ? trial_sub[MW:0] : trial[MW:0];
            q_reg <= {q_reg[W-2:0], trial_ge};
            nlow_reg <= nlow_reg << 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (state_reg == S_FIN)
        begin
            res_reg[comp_reg - 3'd1] <= fin_val;
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the triangle tangent and bitangent generator.
`timescale 1ns / 1ps
`default_nettype none

typedef struct packed {
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] tz;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] bz;
    logic        degen;
} tbn_t;

class tbn_scoreboard;
    tbn_t        expected_tbn[$];
    logic [2:0]  group_size;
    logic [1:0]  corner;
    logic [31:0] held_pos[6];
    logic [31:0] held_tex[4];
    int          errors;
    int          results;
    int          degens;
    int          vertices;

    function new();
        group_size = tbg_pkg::GROUP_SIZE_RESET;
        corner = 0;
        errors = 0;
        results = 0;
        degens = 0;
        vertices = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    function logic [31:0] scaled_div(logic signed [127:0] n, logic signed [127:0] d);
        logic        neg;
        logic [127:0] an;
        logic [127:0] ad;
        logic [127:0] q;
        logic [127:0] lim;
        logic [31:0]  v;
        neg = n[127] ^ d[127];
        an = n[127] ? -n : n;
        ad = d[127] ? -d : d;
        q = ((an << 17) + ad) / (ad << 1);
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        v = (q > lim) ? lim[31:0] : q[31:0];
        return neg ? -v : v;
    endfunction

    function void note_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [31:0] u, logic [31:0] v);
        logic signed [127:0] p0[3];
        logic signed [127:0] ea[3];
        logic signed [127:0] eb[3];
        logic signed [127:0] du1, dv1, du2, dv2, det, t, b;
        logic [31:0] cur[3];
        tbn_t r;
        vertices++;
        cur[0] = px;
        cur[1] = py;
        cur[2] = pz;
        if (corner < 2)
        begin
            for (int k = 0; k < 3; k++) held_pos[corner * 3 + k] = cur[k];
            held_tex[corner * 2] = u;
            held_tex[corner * 2 + 1] = v;
            corner = corner + 1;
            return;
        end
        if (corner == 3)
        begin
            corner = 0;
            return;
        end
        for (int k = 0; k < 3; k++)
        begin
            p0[k] = $signed(held_pos[k]);
            ea[k] = $signed(held_pos[3 + k]);
            ea[k] = ea[k] - p0[k];
            eb[k] = $signed(cur[k]);
            eb[k] = eb[k] - p0[k];
        end
        du1 = $signed(held_tex[2]);
        du1 = du1 - $signed(held_tex[0]);
        dv1 = $signed(held_tex[3]);
        dv1 = dv1 - $signed(held_tex[1]);
        du2 = $signed(u);
        du2 = du2 - $signed(held_tex[0]);
        dv2 = $signed(v);
        dv2 = dv2 - $signed(held_tex[1]);
        det = du1 * dv2 - du2 * dv1;
        r = '0;
        if (det == 0)
        begin
            r.degen = 1'b1;
        end
        else
        begin
            t = dv2 * ea[0] - dv1 * eb[0];
            r.tx = scaled_div(t, det);
            t = dv2 * ea[1] - dv1 * eb[1];
            r.ty = scaled_div(t, det);
            t = dv2 * ea[2] - dv1 * eb[2];
            r.tz = scaled_div(t, det);
            b = du1 * eb[0] - du2 * ea[0];
            r.bx = scaled_div(b, det);
            b = du1 * eb[1] - du2 * ea[1];
            r.by = scaled_div(b, det);
            b = du1 * eb[2] - du2 * ea[2];
            r.bz = scaled_div(b, det);
        end
        expected_tbn = {expected_tbn, r};
        corner = (group_size >= 4) ? 2'd3 : 2'd0;
    endfunction

    task check_result(tbn_t got);
        tbn_t want;
        results++;
        if (expected_tbn.size() == 0)
        begin
            report("unexpected result", got.tx, 32'h0);
            return;
        end
        want = expected_tbn.pop_front();
        if (got.degen) degens++;
        if (got.tx !== want.tx) report("tangent_x", got.tx, want.tx);
        if (got.ty !== want.ty) report("tangent_y", got.ty, want.ty);
        if (got.tz !== want.tz) report("tangent_z", got.tz, want.tz);
        if (got.bx !== want.bx) report("bitangent_x", got.bx, want.bx);
        if (got.by !== want.by) report("bitangent_y", got.by, want.by);
        if (got.bz !== want.bz) report("bitangent_z", got.bz, want.bz);
        if (got.degen !== want.degen) report("degenerate", got.degen, want.degen);
    endtask
endclass

module tb_top;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_OFF = 600;
    localparam int SETTLE = 240;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] pos_x, pos_y, pos_z, tex_u, tex_v;
    logic        out_valid;
    logic        out_ready;
    tbn_t        got;

    tbn_scoreboard sb;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          quiet_cycles;
    logic [31:0] prev_tex[2][2];

    triangle_tangent_bitangent DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
        .out_valid(out_valid), .out_ready(out_ready),
        .tangent_x(got.tx), .tangent_y(got.ty), .tangent_z(got.tz),
        .bitangent_x(got.bx), .bitangent_y(got.by), .bitangent_z(got.bz),
        .degenerate(got.degen)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Monitor: records accepted vertices first, then checks results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready) sb.note_vertex(pos_x, pos_y, pos_z, tex_u, tex_v);
            if (out_valid && out_ready) sb.check_result(got);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog expired with %0d results pending", sb.expected_tbn.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 0;
                hold_cycles--;
            end
            else
            begin
                out_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task send_vtx(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                  logic [31:0] u, logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1;
        pos_x = x;
        pos_y = y;
        pos_z = z;
        tex_u = u;
        tex_v = v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        prev_tex[1] = prev_tex[0];
        prev_tex[0][0] = u;
        prev_tex[0][1] = v;
    endtask

    task drain();
        in_valid = 0;
        while (sb.expected_tbn.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task write_group_size(logic [2:0] value);
        cfg_valid = 1;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.group_size = value;
        @(negedge clk);
        cfg_valid = 0;
    endtask

    function logic [31:0] rand_coord(int mode);
        logic [31:0] r;
        r = $urandom;
        if (mode == 1) r = {{12{r[19]}}, r[19:0]};
        return r;
    endfunction

    task random_vtx();
        int mode;
        logic [31:0] u, v;
        mode = $urandom_range(99);
        if (mode < 40)
        begin
            u = $urandom;
            v = $urandom;
        end
        else if (mode < 70)
        begin
            u = rand_coord(1);
            v = rand_coord(1);
        end
        else if (mode < 85)
        begin
            u = prev_tex[1][0];
            v = prev_tex[1][1];
        end
        else
        begin
            u = prev_tex[0][0] + $urandom_range(2);
            v = prev_tex[0][1] + $urandom_range(2);
        end
        mode = (mode < 40) ? 0 : 1;
        send_vtx(rand_coord(mode), rand_coord(mode), rand_coord(mode), u, v);
    endtask

    initial
    begin
        logic [2:0] phase_cfg[8];
        sb = new();
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = 0;
        in_valid = 0;
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
        tex_u = 0;
        tex_v = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        prev_tex = '{default: '0};
        phase_cfg = '{3'd3, 3'd4, 3'd0, 3'd7, 3'd4, 3'd3, 3'd5, 3'd1};
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Triangles: all zero, unit basis, extreme corners, both saturations.
        send_vtx(0, 0, 0, 0, 0);
        send_vtx(0, 0, 0, 0, 0);
        send_vtx(0, 0, 0, 0, 0);
        send_vtx(0, 0, 0, 0, 0);
        send_vtx(32'h10000, 0, 0, 32'h10000, 0);
        send_vtx(0, 32'h10000, 0, 0, 32'h10000);
        send_vtx(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
        send_vtx(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_vtx(0, 0, 0, 0, 0);
        send_vtx(0, 0, 0, 0, 0);
        send_vtx(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 0);
        send_vtx(32'h80000000, 32'h7fffffff, 0, 0, 1);
        send_vtx(0, 0, 0, 0, 0);
        send_vtx(32'h80000000, 32'h7fffffff, 32'h80000000, 0, 1);
        send_vtx(32'h7fffffff, 32'h80000000, 32'hffffffff, 1, 0);
        drain();
        // Quads, one of them degenerate, then a group size change mid-group.
        write_group_size(3'd4);
        send_vtx(0, 0, 0, 0, 0);
        send_vtx(32'h20000, 32'h10000, 0, 32'h10000, 32'h8000);
        send_vtx(32'h10000, 32'h30000, 32'h10000, 32'h4000, 32'h10000);
        send_vtx(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 32'h55555555, 32'haaaaaaaa);
        send_vtx(5, 6, 7, 8, 9);
        send_vtx(1, 2, 3, 8, 9);
        send_vtx(9, 9, 9, 8, 9);
        drain();
        write_group_size(3'd3);
        send_vtx(4, 4, 4, 4, 4);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            write_group_size(phase_cfg[p]);
            send_idle_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 78 : 25) : 0;
            recv_stall_pct = (p % 4 == 2) ? 78 : ((p % 4 == 3) ? 25 : 0);
            if (p == 2) hold_cycles = HOLD_OFF;
            for (int i = 0; i < 140; i++) random_vtx();
            drain();
        end

        repeat (SETTLE) @(negedge clk);
        $display("covered %0d vertices and %0d results (%0d degenerate) over eight settings",
                 sb.vertices, sb.results, sb.degens);
        $display("in and out of range group sizes, idle and stall mixes, and a %0d cycle hold-off",
                 HOLD_OFF);
        if (sb.errors == 0 && sb.expected_tbn.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
